// ===== sv/evpf_pkg.sv =====
`timescale 1ns / 1ps

package evpf_pkg;

  // number of data words carried on the result channel
  localparam int unsigned OUT_WORDS = 5;
  // byte counter width, enough for an event of 12 bytes with five data words
  localparam int unsigned CNT_W     = 5;
  // mask store address: source byte and command byte
  localparam int unsigned MASK_AW   = 16;
  localparam int unsigned SEQ_W     = 32;

  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_MASK   = 1'b1;
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_GAP   = 1'b1;

  typedef enum logic [1:0] {
    PH_SEQ,
    PH_COUNT,
    PH_EVENT
  } phase_t;

endpackage

// ===== sv/evpf_in_if.sv =====
`timescale 1ns / 1ps

interface evpf_in_if
  import evpf_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] packet_byte;
  logic       packet_end;
  logic [7:0] mask_source;
  logic [7:0] mask_command;
  logic       mask_bit;

  modport source (
    output valid, opcode, packet_byte, packet_end, mask_source, mask_command, mask_bit,
    input  ready
  );
  modport sink (
    input  valid, opcode, packet_byte, packet_end, mask_source, mask_command, mask_bit,
    output ready
  );
endinterface

// ===== sv/evpf_out_if.sv =====
`timescale 1ns / 1ps

interface evpf_out_if
  import evpf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [7:0]       event_command;
  logic [7:0]       event_source;
  logic [15:0]      word_0;
  logic [15:0]      word_1;
  logic [15:0]      word_2;
  logic [15:0]      word_3;
  logic [15:0]      word_4;
  logic [SEQ_W-1:0] received_sequence;
  logic [SEQ_W-1:0] expected_sequence;

  modport source (
    output valid, result_kind, event_command, event_source,
           word_0, word_1, word_2, word_3, word_4,
           received_sequence, expected_sequence,
    input  ready
  );
  modport sink (
    input  valid, result_kind, event_command, event_source,
           word_0, word_1, word_2, word_3, word_4,
           received_sequence, expected_sequence,
    output ready
  );
endinterface

// ===== sv/evpf_ram.sv =====
`timescale 1ns / 1ps

module evpf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/event_packet_parse_filter.sv =====
`timescale 1ns / 1ps

// Event datagram parser and filter.
// in_chan carries one item per cycle: either a datagram byte (opcode byte,
// packet_end on the last byte) or a write of one bit of the source/command
// filter mask. out_chan carries accepted events and sequence gap reports.
// An item is accepted on any cycle with valid and ready high; bytes stream
// back to back at one per cycle while ready holds high. After its last byte
// an event passes through the read stage, for the mask memory read, and then
// the output register. A gap report on the fourth sequence byte does the same.
// The filter mask sits in a 65536 x 1 synchronous RAM, read once per event.
// After reset a clearing pass writes zero to every mask entry, one a cycle;
// in_chan.ready stays low until it completes.
// When the receiver stalls the output register holds its item and the next
// result waits in the read stage; input stalls for as long as that waiting
// result cannot move on.
module event_packet_parse_filter
  import evpf_pkg::*;
#(
  parameter int unsigned DATA_WORDS = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  evpf_in_if.sink    in_chan,
  evpf_out_if.source out_chan
);

  localparam int unsigned EV_LEN = 2 + 2 * DATA_WORDS;
  localparam logic [CNT_W-1:0] EV_LAST = CNT_W'(EV_LEN - 1);
  localparam logic [CNT_W-1:0] SEQ_LAST = CNT_W'(3);

  // mask clearing pass
  logic               clr_active_r;
  logic [MASK_AW-1:0] clr_addr_r;

  // parser state
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [15:0]        grp_r, grp_nxt;
  logic [7:0]         cmd_r, cmd_nxt;
  logic [7:0]         src_r, src_nxt;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [SEQ_W-1:0]   last_r, last_nxt;
  logic               seen_r, seen_nxt;
  logic               in_order_r, in_order_nxt;
  logic               ev_done;
  logic               seq_done;
  logic [SEQ_W-1:0]   expect_seq;

  logic [15:0]        ev_word_nxt [OUT_WORDS];

  // read stage, waits on the mask memory
  logic               s2_valid_r;
  logic               s2_gap_r;
  logic [7:0]         s2_cmd_r;
  logic [7:0]         s2_src_r;
  logic [15:0]        s2_word_r [OUT_WORDS];
  logic [SEQ_W-1:0]   s2_rseq_r;
  logic [SEQ_W-1:0]   s2_eseq_r;
  logic               s2_load;
  logic               s2_emit;
  logic               s2_move;
  logic               load_gap;
  logic [7:0]         load_cmd;
  logic [7:0]         load_src;
  logic [15:0]        load_word [OUT_WORDS];
  logic [SEQ_W-1:0]   load_rseq;
  logic [SEQ_W-1:0]   load_eseq;

  // output register
  logic               out_valid_r;
  logic               out_kind_r;
  logic [7:0]         out_cmd_r;
  logic [7:0]         out_src_r;
  logic [15:0]        out_word_r [OUT_WORDS];
  logic [SEQ_W-1:0]   out_rseq_r;
  logic [SEQ_W-1:0]   out_eseq_r;
  logic               out_free;

  logic               in_acc;
  logic               byte_acc;
  logic               mask_acc;
  logic [7:0]         b;

  logic               ram_wr_en;
  logic [MASK_AW-1:0] ram_wr_addr;
  logic [0:0]         ram_wr_data;
  logic [MASK_AW-1:0] ram_rd_addr;
  logic [0:0]         ram_rd_data;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s2_emit  = s2_gap_r || ram_rd_data[0];
  assign s2_move  = s2_valid_r && (!s2_emit || out_free);

  assign in_chan.ready = !clr_active_r && (!s2_valid_r || s2_move);
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign byte_acc = in_acc && (in_chan.opcode == OP_BYTE);
  assign mask_acc = in_acc && (in_chan.opcode == OP_MASK);
  assign b        = in_chan.packet_byte;

  assign expect_seq = last_r + SEQ_W'(1);

  // ---------------------------------------------------------------------
  // parser next state
  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    grp_nxt      = grp_r;
    cmd_nxt      = cmd_r;
    src_nxt      = src_r;
    seq_nxt      = seq_r;
    last_nxt     = last_r;
    seen_nxt     = seen_r;
    in_order_nxt = in_order_r;
    ev_done      = 1'b0;
    seq_done     = 1'b0;
    if (byte_acc) begin
      unique case (phase_r)
        PH_COUNT: begin
          if (cnt_r == '0) begin
            grp_nxt = {b, 8'h00};
            cnt_nxt = CNT_W'(1);
          end else begin
            grp_nxt = {grp_r[15:8], b};
            cnt_nxt = '0;
            if ({grp_r[15:8], b} != 16'h0000) begin
              phase_nxt = PH_EVENT;
            end
          end
        end
        PH_EVENT: begin
          if (cnt_r == CNT_W'(0)) begin
            cmd_nxt = b;
          end else if (cnt_r == CNT_W'(1)) begin
            src_nxt = b;
          end
          if (cnt_r == EV_LAST) begin
            ev_done = 1'b1;
            cnt_nxt = '0;
            grp_nxt = grp_r - 16'd1;
            if (grp_r == 16'd1) begin
              phase_nxt = PH_COUNT;
            end
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        default: begin
          phase_nxt = PH_SEQ;
          seq_nxt   = {seq_r[SEQ_W-9:0], b};
          if (cnt_r >= SEQ_LAST) begin
            seq_done     = 1'b1;
            seen_nxt     = 1'b1;
            in_order_nxt = !seen_r || (seq_nxt == expect_seq);
            last_nxt     = seq_nxt;
            cnt_nxt      = '0;
            phase_nxt    = PH_COUNT;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      endcase
      if (in_chan.packet_end) begin
        phase_nxt = PH_SEQ;
        cnt_nxt   = '0;
        grp_nxt   = '0;
      end
    end
  end

  // data word buffer, one register per kept word
  for (genvar j = 0; j < OUT_WORDS; j++) begin : g_word
    if (j < DATA_WORDS) begin : g_kept
      localparam logic [CNT_W-1:0] HI_K = CNT_W'(2 + 2 * j);
      localparam logic [CNT_W-1:0] LO_K = CNT_W'(3 + 2 * j);
      logic [15:0] word_r;
      logic [15:0] word_nxt;

      always_comb begin
        word_nxt = word_r;
        if (byte_acc && (phase_r == PH_EVENT)) begin
          if (cnt_r == HI_K) begin
            word_nxt = {b, 8'h00};
          end else if (cnt_r == LO_K) begin
            word_nxt = {word_r[15:8], b};
          end
        end
      end

      always_ff @(posedge clk) begin
        word_r <= word_nxt;
      end

      assign ev_word_nxt[j] = word_nxt;
    end else begin : g_unused
      assign ev_word_nxt[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SEQ;
      cnt_r      <= '0;
      grp_r      <= '0;
      cmd_r      <= '0;
      src_r      <= '0;
      seq_r      <= '0;
      last_r     <= '0;
      seen_r     <= 1'b0;
      in_order_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      grp_r      <= grp_nxt;
      cmd_r      <= cmd_nxt;
      src_r      <= src_nxt;
      seq_r      <= seq_nxt;
      last_r     <= last_nxt;
      seen_r     <= seen_nxt;
      in_order_r <= in_order_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // read stage load: events only from in-order packets, and a gap report for each out-of-order sequence number
  always_comb begin
    s2_load   = (ev_done && in_order_r) || (seq_done && !in_order_nxt);
    load_gap  = seq_done;
    load_cmd  = seq_done ? 8'h00 : cmd_r;
    load_src  = seq_done ? 8'h00 : src_r;
    load_rseq = seq_nxt;
    load_eseq = seq_done ? expect_seq : '0;
    for (int j = 0; j < OUT_WORDS; j++) begin
      load_word[j] = seq_done ? 16'h0000 : ev_word_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= 1'b1;
    end else if (s2_move) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_gap_r  <= load_gap;
      s2_cmd_r  <= load_cmd;
      s2_src_r  <= load_src;
      s2_rseq_r <= load_rseq;
      s2_eseq_r <= load_eseq;
      for (int j = 0; j < OUT_WORDS; j++) begin
        s2_word_r[j] <= load_word[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // mask memory: clearing pass, then single-bit writes from mask items;
  // the read address follows the item in the read stage
  assign ram_wr_en   = clr_active_r || mask_acc;
  assign ram_wr_addr = clr_active_r ? clr_addr_r : {in_chan.mask_source, in_chan.mask_command};
  assign ram_wr_data = clr_active_r ? 1'b0 : in_chan.mask_bit;
  assign ram_rd_addr = s2_load ? {load_src, load_cmd} : {s2_src_r, s2_cmd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + MASK_AW'(1);
      if (clr_addr_r == '1) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  evpf_ram #(
    .WIDTH (1),
    .DEPTH (2 ** MASK_AW)
  ) u_mask_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_move && s2_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && s2_emit) begin
      out_kind_r <= s2_gap_r ? KIND_GAP : KIND_EVENT;
      out_cmd_r  <= s2_cmd_r;
      out_src_r  <= s2_src_r;
      out_rseq_r <= s2_rseq_r;
      out_eseq_r <= s2_eseq_r;
      for (int j = 0; j < OUT_WORDS; j++) begin
        out_word_r[j] <= s2_word_r[j];
      end
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.result_kind       = out_kind_r;
  assign out_chan.event_command     = out_cmd_r;
  assign out_chan.event_source      = out_src_r;
  assign out_chan.word_0            = out_word_r[0];
  assign out_chan.word_1            = out_word_r[1];
  assign out_chan.word_2            = out_word_r[2];
  assign out_chan.word_3            = out_word_r[3];
  assign out_chan.word_4            = out_word_r[4];
  assign out_chan.received_sequence = out_rseq_r;
  assign out_chan.expected_sequence = out_eseq_r;

  // ---------------------------------------------------------------------
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_chan.ready)
    else $error("item accepted during mask clearing pass");

  a_event_phase_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EVENT) |-> (grp_r != 16'h0000))
    else $error("event phase with empty group");

  a_counter_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= EV_LAST)
    else $error("byte counter past end of event");

  a_packet_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_acc && in_chan.packet_end) |=> (phase_r == PH_SEQ) && (cnt_r == '0))
    else $error("parser not back in sequence phase after packet end");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_move) |-> !in_chan.ready ##1 s2_valid_r)
    else $error("read stage item lost or input taken while stalled");

endmodule
